// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/nhm_pkg.sv
package nhm_pkg;

    // CORDIC datapath width and angle table depth
    localparam int CW      = 40;
    localparam int TAB_LEN = 25;

    // pi and ln(2) in Q.30
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint LN2_Q30 = 64'sd744261118;

    // Configuration register indexes
    localparam logic [1:0] REG_REF_ETA     = 2'd0;
    localparam logic [1:0] REG_REF_PHI     = 2'd1;
    localparam logic [1:0] REG_WINDOW_SQ   = 2'd2;
    localparam logic [1:0] REG_ACCEPT_TYPE = 2'd3;

    // CORDIC launch control
    typedef struct packed {
        logic start;
        logic hyp;
    } cordic_ctl_t;

    // atan(2^-n) in Q.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0:    return 30'd843314856;
            5'd1:    return 30'd497837829;
            5'd2:    return 30'd263043836;
            5'd3:    return 30'd133525158;
            5'd4:    return 30'd67021686;
            5'd5:    return 30'd33543515;
            5'd6:    return 30'd16775850;
            5'd7:    return 30'd8388437;
            5'd8:    return 30'd4194282;
            5'd9:    return 30'd2097149;
            5'd10:   return 30'd1048575;
            5'd11:   return 30'd524287;
            5'd12:   return 30'd262143;
            5'd13:   return 30'd131071;
            5'd14:   return 30'd65535;
            5'd15:   return 30'd32767;
            5'd16:   return 30'd16383;
            5'd17:   return 30'd8191;
            5'd18:   return 30'd4095;
            5'd19:   return 30'd2047;
            5'd20:   return 30'd1023;
            5'd21:   return 30'd511;
            5'd22:   return 30'd255;
            5'd23:   return 30'd127;
            5'd24:   return 30'd63;
            default: return 30'd0;
        endcase
    endfunction

    // atanh(2^-i) in Q.30
    function automatic logic [29:0] atanh_q30(input logic [4:0] idx);
        case (idx)
            5'd1:    return 30'd589812981;
            5'd2:    return 30'd274247418;
            5'd3:    return 30'd134923406;
            5'd4:    return 30'd67196450;
            5'd5:    return 30'd33565361;
            5'd6:    return 30'd16778581;
            5'd7:    return 30'd8388778;
            5'd8:    return 30'd4194325;
            5'd9:    return 30'd2097154;
            5'd10:   return 30'd1048576;
            5'd11:   return 30'd524288;
            5'd12:   return 30'd262144;
            5'd13:   return 30'd131072;
            5'd14:   return 30'd65536;
            5'd15:   return 30'd32768;
            5'd16:   return 30'd16384;
            5'd17:   return 30'd8192;
            5'd18:   return 30'd4096;
            5'd19:   return 30'd2048;
            5'd20:   return 30'd1024;
            5'd21:   return 30'd512;
            5'd22:   return 30'd256;
            5'd23:   return 30'd128;
            5'd24:   return 30'd64;
            default: return 30'd0;
        endcase
    endfunction

    // Threshold code to pT in GeV; unmapped codes give 0
    function automatic logic [4:0] pt_map(input logic [3:0] code);
        case (code)
            4'd1:    return 5'd4;
            4'd2:    return 5'd6;
            4'd3:    return 5'd10;
            4'd4:    return 5'd10;
            4'd5:    return 5'd20;
            4'd6:    return 5'd20;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic code_unmapped_f(input logic [3:0] code);
        return (code < 4'd1) || (code > 4'd6);
    endfunction

endpackage

// File: sv/nhm_cordic.sv
module nhm_cordic #(
    parameter int STEPS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nhm_pkg::cordic_ctl_t         ctl,
    input  logic signed [nhm_pkg::CW-1:0] x_init,
    input  logic signed [nhm_pkg::CW-1:0] y_init,
    input  logic signed [nhm_pkg::CW-1:0] acc_init,
    output logic                         done,
    output logic signed [nhm_pkg::CW-1:0] acc
);
    import nhm_pkg::*;

    localparam int NW = $clog2(STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 hyp_reg;
    logic                 rep_done_reg;
    logic [NW-1:0]        n_reg;
    logic [4:0]           i_reg;
    logic [5:0]           rep_reg;
    logic signed [CW-1:0] x_reg, y_reg, acc_reg;
    logic signed [CW-1:0] x_next, y_next, acc_next;
    logic [4:0]           sh;
    logic signed [CW-1:0] xs, ys, ang;

    // One rotation step, vectoring toward y = 0
    always_comb
    begin
        sh  = hyp_reg ? i_reg : 5'(n_reg);
        xs  = x_reg >>> sh;
        ys  = y_reg >>> sh;
        ang = hyp_reg ? signed'({{(CW-30){1'b0}}, atanh_q30(i_reg)})
                      : signed'({{(CW-30){1'b0}}, atan_q30(sh)});
        if (!hyp_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                acc_next = acc_reg + ang;
            end
            else
            begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                acc_next = acc_reg - ang;
            end
        end
        else
        begin
            if (!y_reg[CW-1])
            begin
                x_next   = x_reg - ys;
                y_next   = y_reg - xs;
                acc_next = acc_reg + ang;
            end
            else
            begin
                x_next   = x_reg + ys;
                y_next   = y_reg + xs;
                acc_next = acc_reg - ang;
            end
        end
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (n_reg == NW'(STEPS - 1)))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath and hyperbolic shift sequence (4 and 13 repeat once)
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg        <= x_init;
            y_reg        <= y_init;
            acc_reg      <= acc_init;
            hyp_reg      <= ctl.hyp;
            n_reg        <= '0;
            i_reg        <= 5'd1;
            rep_reg      <= 6'd4;
            rep_done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
            n_reg   <= n_reg + NW'(1);
            if (({1'b0, i_reg} == rep_reg) && !rep_done_reg)
            begin
                rep_done_reg <= 1'b1;
            end
            else
            begin
                if ({1'b0, i_reg} == rep_reg)
                begin
                    rep_reg      <= (rep_reg << 1) + rep_reg + 6'd1;
                    rep_done_reg <= 1'b0;
                end
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// File: sv/nhm_isqrt.sv
module nhm_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;
    logic        fits;

    // Restoring square root, one result bit per cycle
    assign trial = res_reg + bit_reg;
    assign fits  = v_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// File: sv/nearest_hit_eta_phi_match.sv
// Nearest hit in (eta, phi) to a configured reference direction.
// Input channel: in_valid/in_stall carries one hit (type, threshold code,
// x/y/z position, last_hit). Output channel: out_valid/out_stall carries one
// result per event, produced by the hit marked last_hit.
// Configuration: cfg_we/cfg_index/cfg_data write ref_eta, ref_phi, window_sq
// and accept_type; write only while the block is idle.
// A hit of the accepted type goes through two square roots on the shared
// root unit, a search for the ratio exponent (up to 40 powers of two), two
// CORDIC passes (CORDIC_STEPS steps plus launch and result) on the shared
// CORDIC unit, and multiply/compare steps on the shared multiplier. With z
// or the radius zero the roots, the search and the eta pass are skipped;
// with x and y both zero the phi pass is skipped too. A hit of another
// type goes straight to the final state. One hit is in work at a time;
// in_stall stays high until it is done.
// The result sits in an output register; a stalled result holds, and the
// block keeps taking hits of the next event meanwhile. Only a second
// last_hit waits for the register to empty.
// Reset returns the registers to their defaults, clears the event state
// (best distance all ones) and empties the output register.
`include "assert_macros.svh"

module nearest_hit_eta_phi_match #(
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         hit_type,
    input  logic [3:0]         thr_code,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               last_hit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               matched,
    output logic [4:0]         pt_gev,
    output logic               code_unmapped,
    output logic [31:0]        best_dist_sq,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import nhm_pkg::*;

    localparam int SH  = 62 - 2 * COORD_BITS;
    localparam int XSC = 32 - COORD_BITS;
    localparam int AZS = 31 - COORD_BITS;
    localparam int QS  = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [63:0]   RND     = 64'sd1 <<< (29 - ANGLE_FRAC_BITS);
    localparam logic signed [25:0]   PIF     = 26'((PI_Q30 + RND) >>> QS);
    localparam logic signed [CW-1:0] PI_C    = CW'(PI_Q30);
    localparam logic [5:0]           KMAX    = 6'd40;
    localparam logic signed [15:0]   ETA_MAX = 16'sd32767;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_SQX    = 20'h00002,
        S_SQY    = 20'h00004,
        S_SQZ    = 20'h00008,
        S_RGO    = 20'h00010,
        S_RWAIT  = 20'h00020,
        S_PGO    = 20'h00040,
        S_PWAIT  = 20'h00080,
        S_KSRCH  = 20'h00100,
        S_HGO    = 20'h00200,
        S_HWAIT  = 20'h00400,
        S_EKM    = 20'h00800,
        S_ETA    = 20'h01000,
        S_PHGO   = 20'h02000,
        S_PHWAIT = 20'h04000,
        S_DIFF   = 20'h08000,
        S_SQE    = 20'h10000,
        S_SQP    = 20'h20000,
        S_UPD    = 20'h40000,
        S_FIN    = 20'h80000
    } state_t;

    // Low COORD_BITS of a position, sign-extended
    function automatic logic signed [24:0] coord(input logic [15:0] v);
        logic [24:0] w;
        w = 25'(v) << (25 - COORD_BITS);
        return signed'(w) >>> (25 - COORD_BITS);
    endfunction

    state_t state_reg, state_next;

    logic signed [15:0] ref_eta_reg;
    logic signed [14:0] ref_phi_reg;
    logic [23:0]        window_reg;
    logic [2:0]         acc_type_reg;

    logic signed [24:0] x_reg, y_reg, z_reg;
    logic [3:0]         code_reg;
    logic               last_reg;
    logic [63:0]        r2_reg, z2_reg;
    logic [63:0]        a_reg, bsh_reg;
    logic [5:0]         k_reg;
    logic signed [63:0] kl_reg;
    logic signed [15:0] eta_reg;
    logic signed [23:0] phi_reg;
    logic signed [16:0] deta_reg;
    logic signed [25:0] dphi_reg;
    logic [63:0]        d_reg;

    logic [31:0]        best_sq_reg;
    logic [4:0]         best_pt_reg;
    logic               best_unm_reg;

    logic               out_valid_reg;
    logic               matched_reg;
    logic [4:0]         pt_reg;
    logic               unm_reg;
    logic [31:0]        dist_reg;

    logic               in_acc;
    logic               emit;
    logic               xy_zero;
    logic               k_more;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic               sqrt_start, sqrt_done;
    logic [63:0]        sqrt_in;
    logic [31:0]        sqrt_root;
    cordic_ctl_t        cordic_ctl;
    logic signed [CW-1:0] cx, cy, cacc, xw, yw, hacc;
    logic               cordic_done;
    logic [63:0]        bk;
    logic [24:0]        zabs;
    logic signed [63:0] esum, eraw;
    logic signed [15:0] esat;
    logic signed [63:0] phi_wide;
    logic signed [25:0] dphi_raw, dphi_w;
    logic [31:0]        dsat;
    logic               in_window;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign xy_zero  = (x_reg == '0) && (y_reg == '0);
    assign k_more   = (k_reg < KMAX) && (bsh_reg <= a_reg);
    assign emit     = (state_reg == S_FIN) && last_reg && (!out_valid_reg || !out_stall);

    // Shared multiplier
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = {{7{x_reg[24]}}, x_reg};
                mul_b = {{7{x_reg[24]}}, x_reg};
            end
            S_SQY:
            begin
                mul_a = {{7{y_reg[24]}}, y_reg};
                mul_b = {{7{y_reg[24]}}, y_reg};
            end
            S_SQZ:
            begin
                mul_a = {{7{z_reg[24]}}, z_reg};
                mul_b = {{7{z_reg[24]}}, z_reg};
            end
            S_EKM:
            begin
                mul_a = {26'd0, k_reg};
                mul_b = 32'(LN2_Q30);
            end
            S_SQE:
            begin
                mul_a = {{15{deta_reg[16]}}, deta_reg};
                mul_b = {{15{deta_reg[16]}}, deta_reg};
            end
            S_SQP:
            begin
                mul_a = {{6{dphi_reg[25]}}, dphi_reg};
                mul_b = {{6{dphi_reg[25]}}, dphi_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Square root unit: r first, then p
    assign sqrt_start = (state_reg == S_RGO) || (state_reg == S_PGO);
    assign sqrt_in    = (state_reg == S_PGO) ? (r2_reg << SH) + (z2_reg << SH)
                                             : (r2_reg << SH);

    nhm_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // CORDIC launch: hyperbolic for eta, circular for phi
    assign bk = bsh_reg >> 1;
    assign xw = {{(CW-25){x_reg[24]}}, x_reg} <<< XSC;
    assign yw = {{(CW-25){y_reg[24]}}, y_reg} <<< XSC;

    always_comb
    begin
        cordic_ctl = '0;
        cx         = '0;
        cy         = '0;
        cacc       = '0;
        if (state_reg == S_HGO)
        begin
            cordic_ctl.start = 1'b1;
            cordic_ctl.hyp   = 1'b1;
            cx               = signed'(CW'(a_reg + bk));
            cy               = signed'(CW'(a_reg - bk));
        end
        else if ((state_reg == S_PHGO) && !xy_zero)
        begin
            cordic_ctl.start = 1'b1;
            if (x_reg[24])
            begin
                cx   = -xw;
                cy   = -yw;
                cacc = y_reg[24] ? -PI_C : PI_C;
            end
            else
            begin
                cx = xw;
                cy = yw;
            end
        end
    end

    nhm_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cordic_ctl),
        .x_init   (cx),
        .y_init   (cy),
        .acc_init (cacc),
        .done     (cordic_done),
        .acc      (hacc)
    );

    // Eta and phi rounding, phi wrap, distance saturation
    always_comb
    begin
        zabs     = z_reg[24] ? 25'(-z_reg) : 25'(z_reg);
        esum     = kl_reg + ({{(64-CW){hacc[CW-1]}}, hacc} <<< 1) + RND;
        eraw     = esum >>> QS;
        esat     = (eraw > 64'sd32767) ? ETA_MAX : eraw[15:0];
        phi_wide = ({{(64-CW){hacc[CW-1]}}, hacc} + RND) >>> QS;
        dphi_raw = {{11{ref_phi_reg[14]}}, ref_phi_reg} - {{2{phi_reg[23]}}, phi_reg};
        if (dphi_raw > PIF)
        begin
            dphi_w = dphi_raw - (PIF <<< 1);
        end
        else if (dphi_raw < -PIF)
        begin
            dphi_w = dphi_raw + (PIF <<< 1);
        end
        else
        begin
            dphi_w = dphi_raw;
        end
        dsat      = (|d_reg[63:32]) ? '1 : d_reg[31:0];
        in_window = best_sq_reg <= 32'(window_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_valid) state_next = (hit_type == acc_type_reg) ? S_SQX : S_FIN;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_SQZ;
            S_SQZ:    state_next = ((z_reg == '0) || (r2_reg == '0)) ? S_PHGO : S_RGO;
            S_RGO:    state_next = S_RWAIT;
            S_RWAIT:  if (sqrt_done) state_next = S_PGO;
            S_PGO:    state_next = S_PWAIT;
            S_PWAIT:  if (sqrt_done) state_next = S_KSRCH;
            S_KSRCH:  if (!k_more) state_next = S_HGO;
            S_HGO:    state_next = S_HWAIT;
            S_HWAIT:  if (cordic_done) state_next = S_EKM;
            S_EKM:    state_next = S_ETA;
            S_ETA:    state_next = S_PHGO;
            S_PHGO:   state_next = xy_zero ? S_DIFF : S_PHWAIT;
            S_PHWAIT: if (cordic_done) state_next = S_DIFF;
            S_DIFF:   state_next = S_SQE;
            S_SQE:    state_next = S_SQP;
            S_SQP:    state_next = S_UPD;
            S_UPD:    state_next = S_FIN;
            S_FIN:    if (!last_reg || emit) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_eta_reg  <= '0;
            ref_phi_reg  <= '0;
            window_reg   <= 24'd33974;
            acc_type_reg <= 3'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REF_ETA:     ref_eta_reg  <= cfg_data[15:0];
                REG_REF_PHI:     ref_phi_reg  <= cfg_data[14:0];
                REG_WINDOW_SQ:   window_reg   <= cfg_data;
                REG_ACCEPT_TYPE: acc_type_reg <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // Per-hit datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    x_reg    <= coord(pos_x);
                    y_reg    <= coord(pos_y);
                    z_reg    <= coord(pos_z);
                    code_reg <= thr_code;
                    last_reg <= last_hit;
                end
            end
            S_SQX: r2_reg <= $unsigned(prod);
            S_SQY: r2_reg <= r2_reg + $unsigned(prod);
            S_SQZ:
            begin
                z2_reg <= $unsigned(prod);
                if (z_reg == '0)
                begin
                    eta_reg <= '0;
                end
                else if (r2_reg == '0)
                begin
                    eta_reg <= z_reg[24] ? -ETA_MAX : ETA_MAX;
                end
            end
            S_RWAIT:
            begin
                if (sqrt_done)
                begin
                    bsh_reg <= {31'd0, sqrt_root, 1'b0};
                    k_reg   <= '0;
                end
            end
            S_PWAIT:
            begin
                if (sqrt_done)
                begin
                    a_reg <= 64'(sqrt_root) + (64'(zabs) << AZS);
                end
            end
            S_KSRCH:
            begin
                if (k_more)
                begin
                    k_reg   <= k_reg + 6'd1;
                    bsh_reg <= bsh_reg << 1;
                end
            end
            S_EKM: kl_reg  <= prod;
            S_ETA: eta_reg <= z_reg[24] ? -esat : esat;
            S_PHGO:
            begin
                if (xy_zero)
                begin
                    phi_reg <= '0;
                end
            end
            S_PHWAIT:
            begin
                if (cordic_done)
                begin
                    phi_reg <= phi_wide[23:0];
                end
            end
            S_DIFF:
            begin
                deta_reg <= {ref_eta_reg[15], ref_eta_reg} - {eta_reg[15], eta_reg};
                dphi_reg <= dphi_w;
            end
            S_SQE:   d_reg <= $unsigned(prod);
            S_SQP:   d_reg <= d_reg + $unsigned(prod);
            default: ;
        endcase
    end

    // Event state: best hit so far, first of equals kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sq_reg  <= '1;
            best_pt_reg  <= '0;
            best_unm_reg <= 1'b0;
        end
        else if (emit)
        begin
            best_sq_reg  <= '1;
            best_pt_reg  <= '0;
            best_unm_reg <= 1'b0;
        end
        else if ((state_reg == S_UPD) && (dsat < best_sq_reg))
        begin
            best_sq_reg  <= dsat;
            best_pt_reg  <= pt_map(code_reg);
            best_unm_reg <= code_unmapped_f(code_reg);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            matched_reg <= in_window;
            pt_reg      <= in_window ? best_pt_reg : 5'd0;
            unm_reg     <= in_window && best_unm_reg;
            dist_reg    <= best_sq_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign pt_gev        = pt_reg;
    assign code_unmapped = unm_reg;
    assign best_dist_sq  = dist_reg;

    `ASSERT_NOW(a_sqrt_done_wait, sqrt_done, state_reg == S_RWAIT || state_reg == S_PWAIT, "root result arrived while not waiting for it")
    `ASSERT_NOW(a_cordic_done_wait, cordic_done, state_reg == S_HWAIT || state_reg == S_PHWAIT, "CORDIC result arrived while not waiting for it")
    `ASSERT_NEXT(a_clear_after_emit, emit, best_sq_reg == 32'hFFFF_FFFF, "event state not cleared after result")
    `ASSERT_NOW(a_match_in_window, out_valid_reg && matched_reg, dist_reg <= 32'(window_reg), "match reported outside window")

endmodule
